// ----- src/deq_pkg.sv -----
package deq_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SET_FRONT  = 3'd4,
        CMD_SET_BACK   = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic    wr_en;
        status_t status;
    } step_t;

endpackage

// ----- src/double_ended_queue_ring.sv -----
// an accepted item waits in the input registers; its result is then registered at the output
// throughput: one item per cycle while the output is not stalled, set by the single pass
// through the index logic and the two registered read ports of the ring memory
// reset: front and back indices and count clear to zero, ring memory is not
// cleared, entries are read only after being written
module double_ended_queue_ring #(
    parameter  int DEPTH = 64,
    localparam int IW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        command,
    input  logic signed [deq_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [deq_pkg::DATA_W-1:0] front_value,
    output logic signed [deq_pkg::DATA_W-1:0] back_value,
    output logic [CW-1:0]                     entry_count,
    output logic [1:0]                        status
);

    logic                       in_valid_reg;
    logic [2:0]                 cmd_reg;
    logic [deq_pkg::DATA_W-1:0] value_reg;
    logic                       out_valid_reg;
    deq_pkg::status_t           status_reg;
    logic                       exec;
    deq_pkg::step_t             step;
    logic [IW-1:0]              wr_addr;
    logic [IW-1:0]              rd_front_addr;
    logic [IW-1:0]              rd_back_addr;
    logic [CW-1:0]              occupancy;
    logic [deq_pkg::DATA_W-1:0] rd_front_data;
    logic [deq_pkg::DATA_W-1:0] rd_back_data;

    assign exec     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || exec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= deq_pkg::ST_DONE;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (exec)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= step.status;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= command;
            value_reg <= value;
        end
    end

    deq_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .exec          (exec),
        .cmd           (deq_pkg::cmd_t'(cmd_reg)),
        .step          (step),
        .wr_addr       (wr_addr),
        .rd_front_addr (rd_front_addr),
        .rd_back_addr  (rd_back_addr),
        .occupancy     (occupancy)
    );

    deq_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_mem (
        .clk           (clk),
        .rd_en         (exec),
        .wr_en         (exec && step.wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (value_reg),
        .rd_front_addr (rd_front_addr),
        .rd_back_addr  (rd_back_addr),
        .rd_front_data (rd_front_data),
        .rd_back_data  (rd_back_data)
    );

    assign out_valid   = out_valid_reg;
    assign entry_count = occupancy;
    assign status      = status_reg;
    assign front_value = (occupancy == '0) ? '0 : $signed(rd_front_data);
    assign back_value  = (occupancy == '0) ? '0 : $signed(rd_back_data);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status_reg == deq_pkg::ST_FULL) |-> entry_count == CW'(DEPTH))
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status_reg == deq_pkg::ST_EMPTY) |-> entry_count == '0)
        else $error("empty status with entries stored");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !in_valid_reg |=> !out_valid)
        else $error("result shown without an item");

endmodule

// ----- src/deq_ctrl.sv -----
module deq_ctrl #(
    parameter int DEPTH = 64,
    parameter int IW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            exec,
    input  deq_pkg::cmd_t   cmd,
    output deq_pkg::step_t  step,
    output logic [IW-1:0]   wr_addr,
    output logic [IW-1:0]   rd_front_addr,
    output logic [IW-1:0]   rd_back_addr,
    output logic [CW-1:0]   occupancy
);

    logic [IW-1:0] front_reg;
    logic [IW-1:0] front_next;
    logic [IW-1:0] back_reg;
    logic [IW-1:0] back_next;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;
    logic          at_front;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
        return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] i);
        return (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
    endfunction

    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        occ_next    = occ_reg;
        wr_addr     = front_reg;
        step.wr_en  = 1'b0;
        step.status = deq_pkg::ST_DONE;
        at_front    = (cmd == deq_pkg::CMD_PUSH_FRONT) || (cmd == deq_pkg::CMD_POP_FRONT)
                      || (cmd == deq_pkg::CMD_SET_FRONT);
        unique case (cmd)
            deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK:
            begin
                if (occ_reg == CW'(DEPTH))
                begin
                    step.status = deq_pkg::ST_FULL;
                end
                else
                begin
                    occ_next   = occ_reg + 1'b1;
                    step.wr_en = 1'b1;
                    if (occ_reg == '0)
                    begin
                        back_next = front_reg;
                        wr_addr   = front_reg;
                    end
                    else if (at_front)
                    begin
                        front_next = wrap_dec(front_reg);
                        wr_addr    = front_next;
                    end
                    else
                    begin
                        back_next = wrap_inc(back_reg);
                        wr_addr   = back_next;
                    end
                end
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK:
            begin
                if (occ_reg == '0)
                begin
                    step.status = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    occ_next = occ_reg - 1'b1;
                    if (occ_reg == CW'(1))
                        back_next = front_reg;
                    else if (at_front)
                        front_next = wrap_inc(front_reg);
                    else
                        back_next = wrap_dec(back_reg);
                end
            end
            deq_pkg::CMD_SET_FRONT, deq_pkg::CMD_SET_BACK:
            begin
                if (occ_reg == '0)
                begin
                    step.status = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    step.wr_en = 1'b1;
                    wr_addr    = at_front ? front_reg : back_reg;
                end
            end
            default:
            begin
                step.status = deq_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            occ_reg   <= '0;
        end
        else if (exec)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            occ_reg   <= occ_next;
        end
    end

    assign rd_front_addr = front_next;
    assign rd_back_addr  = back_next;
    assign occupancy     = occ_reg;

endmodule

// ----- src/deq_mem.sv -----
module deq_mem #(
    parameter int DEPTH = 64,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic                       wr_en,
    input  logic [IW-1:0]              wr_addr,
    input  logic [deq_pkg::DATA_W-1:0] wr_data,
    input  logic [IW-1:0]              rd_front_addr,
    input  logic [IW-1:0]              rd_back_addr,
    output logic [deq_pkg::DATA_W-1:0] rd_front_data,
    output logic [deq_pkg::DATA_W-1:0] rd_back_data
);

    logic [deq_pkg::DATA_W-1:0] ram [DEPTH];
    logic [deq_pkg::DATA_W-1:0] front_data_reg;
    logic [deq_pkg::DATA_W-1:0] back_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ram[wr_addr] <= wr_data;
    end

    // read after the write of the same cycle, bypassing the array
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            front_data_reg <= (wr_en && (wr_addr == rd_front_addr)) ? wr_data
                                                                    : ram[rd_front_addr];
            back_data_reg  <= (wr_en && (wr_addr == rd_back_addr)) ? wr_data
                                                                   : ram[rd_back_addr];
        end
    end

    assign rd_front_data = front_data_reg;
    assign rd_back_data  = back_data_reg;

endmodule
